// ===== hw/rtl/dtmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtmc_pkg
// shared types for the double to minifloat converter pipeline
// ----------------------------------------------------------------------------
package dtmc_pkg;

  localparam int unsigned ExpRegW  = 4;
  localparam int unsigned FracRegW = 6;

  // config register indexes
  localparam logic RegExpW  = 1'b0;
  localparam logic RegFracW = 1'b1;

  // stage 1 -> stage 2 : normalized operand
  typedef struct packed {
    logic        sign;
    logic        special;   // inf or nan
    logic        zero;
    logic [52:0] sig;       // leading one at bit 52
    logic [12:0] t;         // signed biased target exponent
    logic [3:0]  ew;
    logic [5:0]  fw;
  } norm_t;

  // stage 2 -> stage 3 : shifted significand with rounding info
  typedef struct packed {
    logic        sign;
    logic        special;
    logic        zero;
    logic [52:0] q;
    logic        round_bit;
    logic        sticky;
    logic        normal;
    logic [11:0] texp;      // t-1 when normal
    logic [3:0]  ew;
    logic [5:0]  fw;
  } shft_t;

endpackage

// ===== hw/rtl/dtmc_norm.sv =====
// ----------------------------------------------------------------------------
// dtmc_norm
// unpacks the double, normalizes subnormals and rebiases the exponent
// ----------------------------------------------------------------------------
module dtmc_norm (
  input  logic [63:0]                    source_bits_i,
  input  logic [dtmc_pkg::ExpRegW-1:0]   exp_width_i,
  input  logic [dtmc_pkg::FracRegW-1:0]  frac_width_i,
  output dtmc_pkg::norm_t                norm_o
);

  logic [10:0] dexp;
  logic [51:0] man;
  logic [5:0]  lz;
  logic [3:0]  ew;
  logic [5:0]  fw;
  logic [12:0] bias;
  logic [12:0] e;

  // leading zero count of the mantissa
  always_comb begin
    lz = 6'd52;
    for (int i = 0; i < 52; i++) begin
      if (man[i]) lz = 6'(51 - i);
    end
  end

  always_comb begin
    dexp = source_bits_i[62:52];
    man  = source_bits_i[51:0];
    ew   = (exp_width_i < 4'd2) ? 4'd2 : ((exp_width_i > 4'd11) ? 4'd11 : exp_width_i);
    fw   = (frac_width_i < 6'd1) ? 6'd1 :
           ((frac_width_i > 6'd52) ? 6'd52 : frac_width_i);
    bias = (13'd1 << (ew - 4'd1)) - 13'd1;
    norm_o.sign    = source_bits_i[63];
    norm_o.special = (dexp == 11'h7FF);
    norm_o.zero    = (dexp == 11'd0) && (man == 52'd0);
    norm_o.ew      = ew;
    norm_o.fw      = fw;
    if (dexp == 11'd0) begin
      // p = 51 - lz, e = -1074 + p
      norm_o.sig = {1'b0, man} << (lz + 6'd1);
      e          = 13'(-1074 + 51) - 13'(lz);
    end else begin
      norm_o.sig = {1'b1, man};
      e          = 13'(dexp) - 13'd1023;
    end
    norm_o.t = e + bias;
  end

endmodule

// ===== hw/rtl/dtmc_shift.sv =====
// ----------------------------------------------------------------------------
// dtmc_shift
// aligns the significand to the target fraction width, keeps guard and sticky
// ----------------------------------------------------------------------------
module dtmc_shift (
  input  dtmc_pkg::norm_t norm_i,
  output dtmc_pkg::shft_t shft_o
);

  logic [12:0]  shift;
  logic [6:0]   sh;
  logic [116:0] wide;
  logic [63:0]  lost;

  always_comb begin
    shift = 13'd52 - 13'(norm_i.fw);
    if ($signed(norm_i.t) < 13'sd1) shift = shift + (13'd1 - norm_i.t);
    // beyond 64 everything rounds to zero, 64 is enough for that
    sh   = ($signed(shift) > 13'sd64) ? 7'd64 : shift[6:0];
    wide = {norm_i.sig, 64'd0} >> sh;
    lost = wide[63:0];
    shft_o.sign      = norm_i.sign;
    shft_o.special   = norm_i.special;
    shft_o.zero      = norm_i.zero;
    shft_o.q         = wide[116:64];
    shft_o.round_bit = lost[63];
    shft_o.sticky    = |lost[62:0];
    shft_o.normal    = ($signed(norm_i.t) >= 13'sd1);
    shft_o.texp      = 12'(norm_i.t - 13'd1);
    shft_o.ew        = norm_i.ew;
    shft_o.fw        = norm_i.fw;
  end

endmodule

// ===== hw/rtl/dtmc_round.sv =====
// ----------------------------------------------------------------------------
// dtmc_round
// rounds to nearest even, packs exponent and sign, saturates on overflow and on inf or nan
// ----------------------------------------------------------------------------
module dtmc_round (
  input  dtmc_pkg::shft_t shft_i,
  output logic [63:0]     encoded_o,
  output logic            overflow_o
);

  logic [63:0] q;
  logic [63:0] mag;
  logic [63:0] sat;

  always_comb begin
    sat = ((64'd1 << shft_i.ew) - 64'd1) << shft_i.fw;
    q   = 64'(shft_i.q) + 64'(shft_i.round_bit & (shft_i.sticky | shft_i.q[0]));
    mag = shft_i.normal ? ((64'(shft_i.texp) << shft_i.fw) + q) : q;
    overflow_o = 1'b0;
    if (shft_i.special) begin
      mag        = sat;
      overflow_o = 1'b1;
    end else if (shft_i.zero) begin
      mag = 64'd0;
    end else if (mag >= sat) begin
      mag        = sat;
      overflow_o = 1'b1;
    end
    encoded_o = (64'(shft_i.sign) << (7'(shft_i.ew) + 7'(shft_i.fw))) | mag;
  end

endmodule

// ===== hw/rtl/double_to_minifloat_convert.sv =====
// ----------------------------------------------------------------------------
// double_to_minifloat_convert
// converts an ieee double into a configurable small float format
// ----------------------------------------------------------------------------
// usage
//   - request channel: source_bits_i with valid_i / ready_o
//   - result channel: encoded_o, overflow_o with valid_o / ready_i
//   - config: cfg_we_i writes cfg_data_i into register cfg_idx_i
//     (0 = exp_width, 1 = frac_width); write only while the pipe is empty
//   - three register stages: normalize, align, round/pack
//   - an accepted request is registered in each of these stages in turn before valid_o rises
//   - throughput one request per cycle while the receiver takes results
//   - a stalled receiver freezes each stage whose later stages are all full;
//     a stage with an empty stage after it still moves, so bubbles are squeezed out
//   - ready_o drops only once all three stages hold requests and the
//     output is not taken
//   - reset empties the pipe and sets exp_width 8, frac_width 23
// ----------------------------------------------------------------------------
module double_to_minifloat_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [63:0] source_bits_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [63:0] encoded_o,
  output logic        overflow_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [5:0]  cfg_data_i
);

  logic [dtmc_pkg::ExpRegW-1:0]  exp_width_q;
  logic [dtmc_pkg::FracRegW-1:0] frac_width_q;

  dtmc_pkg::norm_t norm_d, norm_q;
  dtmc_pkg::shft_t shft_d, shft_q;
  logic [63:0]     enc_d, enc_q;
  logic            ovf_d, ovf_q;
  logic            v1_q, v2_q, v3_q;
  logic            en1, en2, en3;

  // per-stage enables: a stage moves when its successor can take it or it is empty
  assign en3     = ready_i | ~v3_q;
  assign en2     = en3 | ~v2_q;
  assign en1     = en2 | ~v1_q;
  assign ready_o = en1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_width_q  <= 4'd8;
      frac_width_q <= 6'd23;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dtmc_pkg::RegExpW:  exp_width_q  <= cfg_data_i[3:0];
        dtmc_pkg::RegFracW: frac_width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dtmc_norm u_norm (
    .source_bits_i (source_bits_i),
    .exp_width_i   (exp_width_q),
    .frac_width_i  (frac_width_q),
    .norm_o        (norm_d)
  );

  dtmc_shift u_shift (
    .norm_i (norm_q),
    .shft_o (shft_d)
  );

  dtmc_round u_round (
    .shft_i     (shft_q),
    .encoded_o  (enc_d),
    .overflow_o (ovf_d)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // payload stages, no reset needed
  always_ff @(posedge clk_i) begin
    if (en1) norm_q <= norm_d;
    if (en2) shft_q <= shft_d;
    if (en3) begin
      enc_q <= enc_d;
      ovf_q <= ovf_d;
    end
  end

  assign valid_o    = v3_q;
  assign encoded_o  = enc_q;
  assign overflow_o = ovf_q;

endmodule
